### rtl/asc_pkg.sv
package asc_pkg;

  // Store and frame geometry.
  localparam int MAX_FRAME_SAMPLES = 2048;
  localparam int MAX_CHANNELS      = 2;
  localparam int FADE_LIMIT        = 1000;
  localparam int STORE_DEPTH       = MAX_FRAME_SAMPLES * MAX_CHANNELS;
  localparam int ADDR_W            = $clog2(STORE_DEPTH);
  localparam int POS_W             = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int FADE_W            = $clog2(FADE_LIMIT + 1);

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int FS_W     = 12;
  localparam int CC_W     = 2;
  localparam int CLIP_W   = 24;
  localparam int THR_W    = 11;
  localparam int TOTAL_W  = 32;

  // Level arithmetic: 1/16 dB per Q16 octave, silence floor of 0.001.
  localparam int LVL_W                 = 13;
  localparam int SILENCE_MAG           = 32;
  localparam logic [22:0] DB_OCTAVE_Q16 = 23'd6313057;

  // Blend divider widths.
  localparam int NUM_W      = 28;
  localparam int DIVIDEND_W = 27;
  localparam int DIVISOR_W  = FADE_W + 1;
  localparam int QUOT_W     = 16;

endpackage

### rtl/asc_ifs.sv
interface asc_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [asc_pkg::SAMPLE_W-1:0]  sample_in;
  logic                                 channel_index;
  logic        [asc_pkg::FS_W-1:0]      frame_samples;
  logic        [asc_pkg::CC_W-1:0]      channel_count;
  logic        [asc_pkg::CLIP_W-1:0]    clip_pos;
  logic        [asc_pkg::CLIP_W-1:0]    clip_frames;
  logic                                 frame_end;
  modport source(output valid, sample_in, channel_index, frame_samples, channel_count,
                 clip_pos, clip_frames, frame_end, input ready);
  modport sink(input valid, sample_in, channel_index, frame_samples, channel_count,
               clip_pos, clip_frames, frame_end, output ready);
endinterface

interface asc_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [asc_pkg::SAMPLE_W-1:0]  sample_out;
  logic                                 channel_out;
  logic                                 frame_end_out;
  logic                                 seam_smoothed;
  logic        [asc_pkg::TOTAL_W-1:0]   seam_total;
  modport source(output valid, sample_out, channel_out, frame_end_out, seam_smoothed,
                 seam_total, input ready);
  modport sink(input valid, sample_out, channel_out, frame_end_out, seam_smoothed,
               seam_total, output ready);
endinterface

interface asc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [asc_pkg::THR_W-1:0]        data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### rtl/asc_store.sv
module asc_store (
  input  logic                              clk,
  input  logic                              we,
  input  logic [asc_pkg::ADDR_W-1:0]        waddr,
  input  logic [asc_pkg::SAMPLE_W-1:0]      wdata,
  input  logic                              re,
  input  logic [asc_pkg::ADDR_W-1:0]        raddr,
  output logic [asc_pkg::SAMPLE_W-1:0]      rdata
);
  import asc_pkg::*;

  logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/asc_level.sv
module asc_level (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [asc_pkg::SAMPLE_W-1:0] sample,
  output logic                               done,
  output logic signed [asc_pkg::LVL_W-1:0]   level
);
  import asc_pkg::*;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_ITER = 2'd1;
  localparam logic [1:0] L_PROD = 2'd2;
  localparam logic [1:0] L_RND  = 2'd3;

  logic [1:0]  state;
  logic        neg;
  logic [3:0]  e_r;
  logic [3:0]  k;
  logic [15:0] y;
  logic [15:0] frac;
  logic [42:0] prod;

  logic [15:0] m;
  logic [3:0]  e;
  logic [31:0] sq;
  logic [16:0] t;
  logic [15:0] y_next;
  logic [19:0] g;
  logic [43:0] rnd;
  logic [11:0] lvl;

  // Magnitude and leading-one position of the incoming sample.
  always_comb begin
    m = sample[SAMPLE_W-1] ? 16'(-sample) : 16'(sample);
    e = '0;
    for (int b = 0; b < 16; b++) begin
      if (m[b]) e = 4'(b);
    end
  end

  // One squaring step of the fractional log2.
  always_comb begin
    sq     = 32'(y) * 32'(y);
    t      = 17'(sq >> 15);
    y_next = t[16] ? t[16:1] : t[15:0];
    g      = {4'd15 - e_r, 16'd0} - 20'(frac);
    rnd    = 44'(prod) + 44'(64'h8000_0000);
    lvl    = rnd[43:32];
  end

  // Sequencer: 16 squaring steps, one scaling multiply, then rounding.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            neg <= sample[SAMPLE_W-1];
            if (m <= 16'(SILENCE_MAG)) begin
              level <= '0;
              done  <= 1'b1;
            end else begin
              e_r   <= e;
              y     <= 16'(m << (4'd15 - e));
              frac  <= '0;
              k     <= '0;
              state <= L_ITER;
            end
          end
        end
        L_ITER: begin
          y    <= y_next;
          frac <= {frac[14:0], t[16]};
          k    <= k + 4'd1;
          if (k == 4'd15) state <= L_PROD;
        end
        L_PROD: begin
          prod  <= 43'(g) * 43'(DB_OCTAVE_Q16);
          state <= L_RND;
        end
        L_RND: begin
          level <= neg ? $signed({1'b0, lvl}) : -$signed({1'b0, lvl});
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

### rtl/asc_div.sv
module asc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [asc_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [asc_pkg::DIVISOR_W-1:0]     divisor,
  output logic                              done,
  output logic [asc_pkg::QUOT_W-1:0]        quotient
);
  import asc_pkg::*;

  logic                    busy;
  logic [3:0]              cnt;
  logic [DIVISOR_W-1:0]    rem;
  logic [DIVISOR_W-1:0]    dv;
  logic [QUOT_W-1:0]       low;
  logic [DIVISOR_W:0]      t;
  logic                    ge;
  logic [DIVISOR_W-1:0]    rem_next;

  // One restoring step: the quotient is known to fit in QUOT_W bits.
  always_comb begin
    t        = {rem, low[QUOT_W-1]};
    ge       = t >= {1'b0, dv};
    rem_next = ge ? DIVISOR_W'(t - {1'b0, dv}) : t[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= dividend[DIVIDEND_W-1:QUOT_W];
        low  <= dividend[QUOT_W-1:0];
        dv   <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem      <= rem_next;
        low      <= {low[QUOT_W-2:0], 1'b0};
        quotient <= {quotient[QUOT_W-2:0], ge};
        cnt      <= cnt + 4'd1;
        if (cnt == 4'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/audio_seam_crossfade_unit.sv
// Channel     Dir  Payload
// sample_ch   in   sample_in, channel_index, frame_samples, channel_count,
//                  clip_pos, clip_frames, frame_end
// result_ch   out  sample_out, channel_out, frame_end_out, seam_smoothed, seam_total
// cfg_ch      in   threshold in 1/16 dB (data)
//
// One item at a time. A crossfaded item also waits for the 16-step restoring
// divider. The first item of a frame that opens a clip with a stored frame adds
// one store read and two passes of the log2 unit (a silent sample's level skips
// the squaring steps). A finished result waits in the output register while the
// next item is taken; reset is synchronous and clears all control state.
module audio_seam_crossfade_unit (
  input  logic  clk,
  input  logic  rst,
  asc_sample_if.sink   sample_ch,
  asc_result_if.source result_ch,
  asc_cfg_if.sink      cfg_ch
);
  import asc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_OPEN   = 4'd1;
  localparam logic [3:0] S_LVA_RD = 4'd2;
  localparam logic [3:0] S_LVA    = 4'd3;
  localparam logic [3:0] S_LVX    = 4'd4;
  localparam logic [3:0] S_BODY   = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_DIVS   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state;

  // Block state.
  logic [THR_W-1:0]    threshold;
  logic [POS_W-1:0]    stored_length;
  logic                stored_valid;
  logic                fade_active;
  logic [FADE_W-1:0]   fade_length;
  logic [POS_W-1:0]    frame_position;
  logic [TOTAL_W-1:0]  seam_counter;
  logic                frame_open;

  // Item held while it is worked on.
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       ch_r;
  logic [POS_W-1:0]           fs_r;
  logic [CC_W-1:0]            cc_r;
  logic                       first_r;
  logic                       last_r;
  logic                       fend_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic signed [LVL_W-1:0]    la;
  logic signed [NUM_W-2:0]    prod_p;
  logic signed [NUM_W-2:0]    prod_x;
  logic                       neg_r;

  // Memory, level unit and divider hookup.
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0]  mem_rdata;
  logic                 lvl_start, lvl_done;
  logic signed [SAMPLE_W-1:0] lvl_sample;
  logic signed [LVL_W-1:0]    lvl_res;
  logic                 div_start, div_done;
  logic [DIVIDEND_W-1:0] dividend;
  logic [QUOT_W-1:0]    quot;

  logic [CC_W-1:0]          cc_in;
  logic [POS_W-1:0]         fs_in;
  logic                     lane_ok;
  logic                     fade_go;
  logic [POS_W-1:0]         fade_pick;
  logic signed [LVL_W:0]    diff;
  logic [LVL_W:0]           diff_abs;
  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         mag;
  logic                     out_free;

  assign sample_ch.ready = (state == S_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_free        = !result_ch.valid || result_ch.ready;

  // Clamping of channel count and frame size at intake.
  always_comb begin
    if (sample_ch.channel_count == '0) cc_in = CC_W'(1);
    else if (sample_ch.channel_count > CC_W'(MAX_CHANNELS)) cc_in = CC_W'(MAX_CHANNELS);
    else cc_in = sample_ch.channel_count;
    if (sample_ch.frame_samples > FS_W'(MAX_FRAME_SAMPLES)) fs_in = POS_W'(MAX_FRAME_SAMPLES);
    else fs_in = POS_W'(sample_ch.frame_samples);
  end

  // Lane checks, fade decision and seam level step.
  always_comb begin
    lane_ok = ({1'b0, ch_r} < cc_r) && (frame_position < POS_W'(MAX_FRAME_SAMPLES));
    fade_go = fade_active && lane_ok && (frame_position < POS_W'(fade_length)) &&
              (frame_position < stored_length);
    diff     = (LVL_W + 1)'(la) - (LVL_W + 1)'(lvl_res);
    diff_abs = diff[LVL_W] ? (LVL_W + 1)'(-diff) : (LVL_W + 1)'(diff);
    fade_pick = POS_W'(FADE_LIMIT);
    if (fade_pick > fs_r) fade_pick = fs_r;
    if (fade_pick > stored_length) fade_pick = stored_length;
    num = NUM_W'(prod_p) + NUM_W'(prod_x);
    mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    dividend = DIVIDEND_W'({mag, 1'b0}) + DIVIDEND_W'(fade_length);
  end

  // Memory port selection.
  always_comb begin
    mem_we    = (state == S_BODY) && last_r && lane_ok;
    mem_waddr = ADDR_W'(frame_position * cc_r) + ADDR_W'(ch_r);
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (state == S_OPEN) begin
      mem_re    = 1'b1;
      mem_raddr = ADDR_W'((stored_length - POS_W'(1)) * cc_r);
    end else if (state == S_FCHK) begin
      mem_re    = fade_go;
      mem_raddr = ADDR_W'((stored_length - POS_W'(1) - frame_position) * cc_r) +
                  ADDR_W'(ch_r);
    end
  end

  assign lvl_start  = (state == S_LVA_RD) || ((state == S_LVA) && lvl_done);
  assign lvl_sample = (state == S_LVA_RD) ?
                      ((stored_length != '0) ? $signed(mem_rdata) : '0) : x_r;
  assign div_start  = (state == S_DIVS);

  asc_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (x_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  asc_level u_level (
    .clk    (clk),
    .rst    (rst),
    .start  (lvl_start),
    .sample (lvl_sample),
    .done   (lvl_done),
    .level  (lvl_res)
  );

  asc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  ({fade_length, 1'b0}),
    .done     (div_done),
    .quotient (quot)
  );

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_ch.valid) begin
      threshold <= cfg_ch.data;
    end
  end

  // Item sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      stored_length    <= '0;
      stored_valid     <= 1'b0;
      fade_active      <= 1'b0;
      fade_length      <= '0;
      frame_position   <= '0;
      seam_counter     <= '0;
      frame_open       <= 1'b0;
      result_ch.valid  <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready && (state != S_FIN)) result_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (sample_ch.valid) begin
            x_r     <= sample_ch.sample_in;
            ch_r    <= sample_ch.channel_index;
            fs_r    <= fs_in;
            cc_r    <= cc_in;
            first_r <= (sample_ch.clip_frames != '0) && (sample_ch.clip_pos == '0);
            last_r  <= (sample_ch.clip_frames != '0) && (sample_ch.clip_pos != '0) &&
                       (sample_ch.clip_pos == sample_ch.clip_frames - CLIP_W'(1));
            fend_r  <= sample_ch.frame_end;
            state   <= S_OPEN;
          end
        end
        S_OPEN: begin
          state <= S_BODY;
          if (!frame_open) begin
            frame_open     <= 1'b1;
            frame_position <= '0;
            fade_active    <= 1'b0;
            if (first_r) begin
              stored_valid <= 1'b0;
              if (stored_valid) state <= S_LVA_RD;
            end
          end
        end
        S_LVA_RD: state <= S_LVA;
        S_LVA: begin
          if (lvl_done) begin
            la    <= lvl_res;
            state <= S_LVX;
          end
        end
        S_LVX: begin
          if (lvl_done) begin
            if (diff_abs > (LVL_W + 1)'(threshold)) begin
              fade_length  <= FADE_W'(fade_pick);
              fade_active  <= (fade_pick != '0);
              seam_counter <= seam_counter + TOTAL_W'(1);
            end
            state <= S_BODY;
          end
        end
        S_BODY: begin
          if (last_r && lane_ok) begin
            stored_length <= fs_r;
            stored_valid  <= 1'b1;
          end
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (fade_go) begin
            state <= S_MUL;
          end else begin
            y_r   <= x_r;
            state <= S_FIN;
          end
        end
        S_MUL: begin
          prod_p <= $signed(mem_rdata) *
                    $signed({1'b0, FADE_W'(POS_W'(fade_length) - frame_position)});
          prod_x <= x_r * $signed({1'b0, FADE_W'(frame_position)});
          state  <= S_DIVS;
        end
        S_DIVS: begin
          neg_r <= num[NUM_W-1];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            y_r   <= neg_r ? SAMPLE_W'(-quot) : SAMPLE_W'(quot);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            result_ch.valid         <= 1'b1;
            result_ch.sample_out    <= y_r;
            result_ch.channel_out   <= ch_r;
            result_ch.frame_end_out <= fend_r;
            result_ch.seam_smoothed <= fade_active;
            result_ch.seam_total    <= seam_counter;
            // The end of a frame resets the position; otherwise the last lane steps it.
            if (fend_r) begin
              frame_open     <= 1'b0;
              frame_position <= '0;
              fade_active    <= 1'b0;
            end else if (({1'b0, ch_r} == cc_r - CC_W'(1)) &&
                         (frame_position < POS_W'(MAX_FRAME_SAMPLES))) begin
              frame_position <= frame_position + POS_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The seam count only ever steps by one, and only at the end of a level compare.
  assert property (@(posedge clk) disable iff (rst)
    (seam_counter != $past(seam_counter)) |->
      ((seam_counter == $past(seam_counter) + TOTAL_W'(1)) && ($past(state) == S_LVX)))
    else $error("seam counter moved outside a seam decision");

  // A running fade always has a non-zero length to divide by.
  assert property (@(posedge clk) disable iff (rst)
    fade_active |-> (fade_length != '0))
    else $error("fade active with zero length");

  // The frame position never passes the frame limit.
  assert property (@(posedge clk) disable iff (rst)
    frame_position <= POS_W'(MAX_FRAME_SAMPLES))
    else $error("frame position beyond limit");

  // The store is never written while a fade read is outstanding.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> !mem_we)
    else $error("store written during a fade read");

endmodule
